// ===== rtl/plc_pkg.sv =====
// shared types and constants of the pinned lru cell cache
`default_nettype none
package plc_pkg;
  localparam int unsigned CELLS    = 64;
  localparam int unsigned PIN_BITS = 8;
  localparam int unsigned IDX_W    = $clog2(CELLS);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  // request modes
  localparam logic [1:0] MODE_GET  = 2'd0;
  localparam logic [1:0] MODE_REL  = 2'd1;
  localparam logic [1:0] MODE_FILL = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_PINNED  = 3'd2;
  localparam logic [2:0] ST_FILLED  = 3'd3;
  localparam logic [2:0] ST_FFAIL   = 3'd4;
  localparam logic [2:0] ST_REL_OK  = 3'd5;
  localparam logic [2:0] ST_INVALID = 3'd6;
  localparam logic [2:0] ST_BUSY    = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] glyph_code;
    logic [15:0] face_id;
    logic [15:0] size_pixels;
    logic [7:0]  render_style;
    logic [15:0] target_cell;
    logic        fill_ok;
    logic [15:0] fill_width;
    logic [15:0] fill_height;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  cell_index;
    logic [15:0] glyph_width;
    logic [15:0] glyph_height;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } rsp_t;

  // one cell record as held in the cell memory
  typedef struct packed {
    logic                valid;
    logic [PIN_BITS-1:0] pins;
    logic [IDX_W-1:0]    age;
    logic [31:0]         glyph;
    logic [39:0]         attrs;
    logic [31:0]         dims;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

// ===== rtl/plc_req_if.sv =====
// request channel interface
`default_nettype none
interface plc_req_if;
  import plc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/plc_rsp_if.sv =====
// result channel interface
`default_nettype none
interface plc_rsp_if;
  import plc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pinned_lru_cell_cache.sv =====
// top level of the pinned lru cell cache
// Usage: requests arrive on req_i (get by key, release by cell, fill result),
// one result word leaves on rsp_o for every request word.
// Cell records (key, dims, valid, pin count, age rank) live in one memory of
// CELLS entries with a registered read.
// Each request takes two sweeps of that memory port: a scan that reads every
// cell to find the key match, the least recent unpinned cell and the target
// cell, then a read-modify-write pass that renumbers ages and updates the
// target. Busy, invalid and all-pinned requests skip the second sweep.
// One request is in work at a time; ready is high only between requests.
// A finished result sits in the output register while the next request is
// already worked on; if rsp_o is stalled the block waits to hand over.
// Reset clears valid, pin counts and age ranks at once through one
// written-flag per cell (cell i starts with rank i), with no clearing pass,
// and zeroes the hit, miss and eviction counters.
`default_nettype none
module pinned_lru_cell_cache (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plc_req_if.sink   req_i,
  plc_rsp_if.source rsp_o
);
  import plc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [2:0] K_HIT  = 3'd0;
  localparam logic [2:0] K_MISS = 3'd1;
  localparam logic [2:0] K_FOK  = 3'd2;
  localparam logic [2:0] K_FBAD = 3'd3;
  localparam logic [2:0] K_REL  = 3'd4;

  localparam logic [IDX_W-1:0] AGE_TOP = IDX_W'(CELLS - 1);

  logic [2:0]        state_q, state_d;
  req_t              req_q, req_d;
  logic [IDX_W:0]    cnt_q, cnt_d;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_addr_q;
  logic [CELLS-1:0]  touched_q, touched_d;

  logic              hit_fnd_q, hit_fnd_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d, hit_age_q, hit_age_d;
  logic [31:0]       hit_dims_q, hit_dims_d;
  logic              vic_fnd_q, vic_fnd_d, vic_valid_q, vic_valid_d;
  logic [IDX_W-1:0]  vic_idx_q, vic_idx_d, vic_age_q, vic_age_d;
  logic [IDX_W-1:0]  tgt_age_q, tgt_age_d;
  logic [PIN_BITS-1:0] tgt_pins_q, tgt_pins_d;

  logic [2:0]        kind_q, kind_d;
  logic [IDX_W-1:0]  upd_idx_q, upd_idx_d, upd_age_q, upd_age_d;
  logic [2:0]        res_st_q, res_st_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [31:0]       res_dims_q, res_dims_d;

  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_cell_q, pend_cell_d;
  logic [31:0]       pend_glyph_q, pend_glyph_d;
  logic [39:0]       pend_attrs_q, pend_attrs_d;
  logic [31:0]       hit_tot_q, hit_tot_d, miss_tot_q, miss_tot_d, ev_tot_q, ev_tot_d;

  logic              out_vld_q, out_vld_d;
  rsp_t              out_q, out_d;

  logic              re;
  logic              we;
  logic [ENTRY_W-1:0] rdata;
  entry_t            ent, wr_ent, rst_ent;
  logic [39:0]       key_attrs;
  logic [IDX_W-1:0]  tgt_idx;
  logic              last_rd;

  // cell record memory
  plc_ram #(.Width(ENTRY_W), .Depth(CELLS)) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (rd_addr_q),
    .wdata_i (wr_ent),
    .re_i    (re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // read side: never-written cells read as their reset record
  always_comb begin
    rst_ent       = '0;
    rst_ent.age   = rd_addr_q;
    ent           = touched_q[rd_addr_q] ? entry_t'(rdata) : rst_ent;
    re            = ((state_q == S_SCAN) || (state_q == S_UPD)) &&
                    (cnt_q < (IDX_W+1)'(CELLS));
    last_rd       = rd_vld_q && (rd_addr_q == AGE_TOP);
    key_attrs     = {req_q.face_id, req_q.size_pixels, req_q.render_style};
    tgt_idx       = (req_q.mode == MODE_FILL) ? pend_cell_q : req_q.target_cell[IDX_W-1:0];
  end

  // write side of the update sweep
  always_comb begin
    wr_ent = ent;
    if (ent.age > upd_age_q) begin
      wr_ent.age = ent.age - 1'b1;
    end
    if (rd_addr_q == upd_idx_q) begin
      case (kind_q)
        K_HIT: begin
          if (ent.pins != PIN_MAX) wr_ent.pins = ent.pins + 1'b1;
          wr_ent.age = AGE_TOP;
        end
        K_MISS: begin
          wr_ent.valid = 1'b0;
          wr_ent.age   = AGE_TOP;
        end
        K_FOK: begin
          wr_ent.valid = 1'b1;
          wr_ent.pins  = PIN_BITS'(1);
          wr_ent.glyph = pend_glyph_q;
          wr_ent.attrs = pend_attrs_q;
          wr_ent.dims  = {req_q.fill_width, req_q.fill_height};
          wr_ent.age   = AGE_TOP;
        end
        K_FBAD: begin
          wr_ent.valid = 1'b0;
          wr_ent.age   = AGE_TOP;
        end
        default: begin
          wr_ent.pins = ent.pins - 1'b1;
        end
      endcase
    end
    we = (state_q == S_UPD) && rd_vld_q;
  end

  // sequencer, scan bookkeeping and decision
  always_comb begin
    state_d = state_q;   req_d = req_q;   cnt_d = cnt_q;   touched_d = touched_q;
    hit_fnd_d = hit_fnd_q; hit_idx_d = hit_idx_q; hit_age_d = hit_age_q;
    hit_dims_d = hit_dims_q;
    vic_fnd_d = vic_fnd_q; vic_valid_d = vic_valid_q; vic_idx_d = vic_idx_q;
    vic_age_d = vic_age_q; tgt_age_d = tgt_age_q; tgt_pins_d = tgt_pins_q;
    kind_d = kind_q; upd_idx_d = upd_idx_q; upd_age_d = upd_age_q;
    res_st_d = res_st_q; res_idx_d = res_idx_q; res_dims_d = res_dims_q;
    pend_d = pend_q; pend_cell_d = pend_cell_q; pend_glyph_d = pend_glyph_q;
    pend_attrs_d = pend_attrs_q;
    hit_tot_d = hit_tot_q; miss_tot_d = miss_tot_q; ev_tot_d = ev_tot_q;
    out_vld_d = out_vld_q; out_d = out_q;

    if (out_vld_q && rsp_o.ready) out_vld_d = 1'b0;
    if (re) cnt_d = cnt_q + 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d     = req_i.data;
          cnt_d     = '0;
          hit_fnd_d = 1'b0;
          vic_fnd_d = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if (!hit_fnd_q && ent.valid && ent.glyph == req_q.glyph_code &&
              ent.attrs == key_attrs) begin
            hit_fnd_d  = 1'b1;
            hit_idx_d  = rd_addr_q;
            hit_age_d  = ent.age;
            hit_dims_d = ent.dims;
          end
          if (ent.pins == '0 && (!vic_fnd_q || ent.age < vic_age_q)) begin
            vic_fnd_d   = 1'b1;
            vic_idx_d   = rd_addr_q;
            vic_age_d   = ent.age;
            vic_valid_d = ent.valid;
          end
          if (rd_addr_q == tgt_idx) begin
            tgt_age_d  = ent.age;
            tgt_pins_d = ent.pins;
          end
          if (last_rd) state_d = S_DEC;
        end
      end
      S_DEC: begin
        res_st_d   = ST_INVALID;
        res_idx_d  = '0;
        res_dims_d = '0;
        upd_age_d  = AGE_TOP;
        kind_d     = K_REL;
        state_d    = S_OUT;
        case (req_q.mode)
          MODE_GET: begin
            if (pend_q) begin
              res_st_d = ST_BUSY;
            end else if (hit_fnd_q) begin
              hit_tot_d  = hit_tot_q + 1'b1;
              kind_d     = K_HIT;
              upd_idx_d  = hit_idx_q;
              upd_age_d  = hit_age_q;
              res_st_d   = ST_HIT;
              res_idx_d  = hit_idx_q;
              res_dims_d = hit_dims_q;
              state_d    = S_UPD;
            end else begin
              miss_tot_d = miss_tot_q + 1'b1;
              if (!vic_fnd_q) begin
                res_st_d = ST_PINNED;
              end else begin
                if (vic_valid_q) ev_tot_d = ev_tot_q + 1'b1;
                kind_d       = K_MISS;
                upd_idx_d    = vic_idx_q;
                upd_age_d    = vic_age_q;
                pend_d       = 1'b1;
                pend_cell_d  = vic_idx_q;
                pend_glyph_d = req_q.glyph_code;
                pend_attrs_d = key_attrs;
                res_st_d     = ST_MISS;
                res_idx_d    = vic_idx_q;
                state_d      = S_UPD;
              end
            end
          end
          MODE_REL: begin
            if (req_q.target_cell < 16'(CELLS) && tgt_pins_q != '0) begin
              upd_idx_d = tgt_idx;
              res_st_d  = ST_REL_OK;
              res_idx_d = tgt_idx;
              state_d   = S_UPD;
            end
          end
          MODE_FILL: begin
            if (pend_q) begin
              pend_d    = 1'b0;
              upd_idx_d = pend_cell_q;
              upd_age_d = tgt_age_q;
              res_idx_d = pend_cell_q;
              state_d   = S_UPD;
              if (req_q.fill_ok) begin
                kind_d     = K_FOK;
                res_st_d   = ST_FILLED;
                res_dims_d = {req_q.fill_width, req_q.fill_height};
              end else begin
                kind_d   = K_FBAD;
                res_st_d = ST_FFAIL;
              end
            end
          end
          default: begin
            res_st_d = ST_INVALID;
          end
        endcase
        cnt_d = '0;
      end
      S_UPD: begin
        if (we) touched_d[rd_addr_q] = 1'b1;
        if (last_rd) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d            = 1'b1;
          out_d.status         = res_st_q;
          out_d.cell_index     = 6'(res_idx_q);
          out_d.glyph_width    = res_dims_q[31:16];
          out_d.glyph_height   = res_dims_q[15:0];
          out_d.hit_count      = hit_tot_q;
          out_d.miss_count     = miss_tot_q;
          out_d.eviction_count = ev_tot_q;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      touched_q <= '0;
      pend_q    <= 1'b0;
      pend_cell_q <= '0;
      pend_glyph_q <= '0;
      pend_attrs_q <= '0;
      hit_tot_q <= '0;
      miss_tot_q <= '0;
      ev_tot_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= re;
      touched_q <= touched_d;
      pend_q    <= pend_d;
      pend_cell_q <= pend_cell_d;
      pend_glyph_q <= pend_glyph_d;
      pend_attrs_q <= pend_attrs_d;
      hit_tot_q <= hit_tot_d;
      miss_tot_q <= miss_tot_d;
      ev_tot_q  <= ev_tot_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;   rd_addr_q <= cnt_q[IDX_W-1:0];
    hit_fnd_q <= hit_fnd_d; hit_idx_q <= hit_idx_d; hit_age_q <= hit_age_d;
    hit_dims_q <= hit_dims_d;
    vic_fnd_q <= vic_fnd_d; vic_valid_q <= vic_valid_d; vic_idx_q <= vic_idx_d;
    vic_age_q <= vic_age_d; tgt_age_q <= tgt_age_d; tgt_pins_q <= tgt_pins_d;
    kind_q <= kind_d; upd_idx_q <= upd_idx_d; upd_age_q <= upd_age_d;
    res_st_q <= res_st_d; res_idx_q <= res_idx_d; res_dims_q <= res_dims_d;
    out_q <= out_d;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;
endmodule
`default_nettype wire

// ===== rtl/plc_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module plc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/plc_checker.sv =====
// port checker of the pinned lru cell cache and its bind
`default_nettype none
module plc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [5:0]  cell_index,
  input wire logic [15:0] glyph_width,
  input wire logic [15:0] glyph_height
);
  import plc_pkg::*;

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cell_index))
    else $error("stalled result word changed");

  // one request in work at a time
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // refused requests carry no cell
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_BUSY || status == ST_INVALID || status == ST_PINNED)
    |-> cell_index == '0)
    else $error("cell index on refused request");

  // dimensions only on hit or fill
  a_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_HIT && status != ST_FILLED
    |-> glyph_width == '0 && glyph_height == '0)
    else $error("dimensions on result without cell data");
endmodule

bind pinned_lru_cell_cache plc_checker u_plc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (req_i.valid),
  .in_ready     (req_i.ready),
  .out_valid    (rsp_o.valid),
  .out_ready    (rsp_o.ready),
  .status       (rsp_o.data.status),
  .cell_index   (rsp_o.data.cell_index),
  .glyph_width  (rsp_o.data.glyph_width),
  .glyph_height (rsp_o.data.glyph_height)
);
`default_nettype wire

// ===== test/tb_pinned_lru_cell_cache.sv =====
// testbench of the pinned lru cell cache: scoreboard against a behavioral cache model
`timescale 1ns / 1ps
module tb_pinned_lru_cell_cache;
  import plc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plc_req_if req_if ();
  plc_rsp_if rsp_if ();

  pinned_lru_cell_cache uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // cache model state
  logic [31:0]         m_glyph [CELLS];
  logic [39:0]         m_attrs [CELLS];
  logic                m_valid [CELLS];
  logic [PIN_BITS-1:0] m_pins  [CELLS];
  logic [31:0]         m_dims  [CELLS];
  int unsigned         m_age   [CELLS];
  logic                m_pend;
  int unsigned         m_pend_cell;
  logic [31:0]         m_pend_glyph;
  logic [39:0]         m_pend_attrs;
  logic [31:0]         m_hits, m_misses, m_evicts;

  req_t req_q [$];
  rsp_t cache_rsp_q [$];
  int   errors = 0;
  int   send_idle_pct = 12;
  int   recv_idle_pct = 49;
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;

  // keys reused by the random part so that hits happen
  logic [31:0] key_glyph [8];
  logic [39:0] key_attrs [8];

  function automatic void touch_cell(int unsigned c);
    int unsigned a;
    a = m_age[c];
    for (int i = 0; i < CELLS; i++)
      if (m_age[i] > a) m_age[i]--;
    m_age[c] = CELLS - 1;
  endfunction

  function automatic rsp_t cache_result(logic [2:0] st, int unsigned idx, logic [31:0] dims);
    rsp_t r;
    r.status = st;
    r.cell_index = idx[5:0];
    r.glyph_width = dims[31:16];
    r.glyph_height = dims[15:0];
    r.hit_count = m_hits;
    r.miss_count = m_misses;
    r.eviction_count = m_evicts;
    return r;
  endfunction

  function automatic rsp_t cache_apply(req_t q);
    logic [39:0] attrs;
    int          best;
    int unsigned t;
    attrs = {q.face_id, q.size_pixels, q.render_style};
    best = -1;
    t = q.target_cell;
    case (q.mode)
      MODE_GET: begin
        if (m_pend) return cache_result(ST_BUSY, 0, 0);
        for (int i = 0; i < CELLS; i++)
          if (m_valid[i] && m_glyph[i] == q.glyph_code && m_attrs[i] == attrs) begin
            m_hits++;
            if (m_pins[i] != PIN_MAX) m_pins[i]++;
            touch_cell(i);
            return cache_result(ST_HIT, i, m_dims[i]);
          end
        m_misses++;
        for (int i = 0; i < CELLS; i++)
          if (m_pins[i] == 0 && (best < 0 || m_age[i] < m_age[best])) best = i;
        if (best < 0) return cache_result(ST_PINNED, 0, 0);
        if (m_valid[best]) m_evicts++;
        m_valid[best] = 1'b0;
        touch_cell(best);
        m_pend = 1'b1;
        m_pend_cell = best;
        m_pend_glyph = q.glyph_code;
        m_pend_attrs = attrs;
        return cache_result(ST_MISS, best, 0);
      end
      MODE_REL: begin
        if (t >= CELLS || m_pins[t] == 0) return cache_result(ST_INVALID, 0, 0);
        m_pins[t]--;
        return cache_result(ST_REL_OK, t, 0);
      end
      MODE_FILL: begin
        if (!m_pend) return cache_result(ST_INVALID, 0, 0);
        m_pend = 1'b0;
        touch_cell(m_pend_cell);
        if (q.fill_ok) begin
          m_glyph[m_pend_cell] = m_pend_glyph;
          m_attrs[m_pend_cell] = m_pend_attrs;
          m_dims[m_pend_cell] = {q.fill_width, q.fill_height};
          m_valid[m_pend_cell] = 1'b1;
          m_pins[m_pend_cell] = PIN_BITS'(1);
          return cache_result(ST_FILLED, m_pend_cell, m_dims[m_pend_cell]);
        end
        m_valid[m_pend_cell] = 1'b0;
        return cache_result(ST_FFAIL, m_pend_cell, 0);
      end
      default: return cache_result(ST_INVALID, 0, 0);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic req_t rand_word(logic [1:0] mode);
    req_t q;
    q = '0;
    q.mode = mode;
    q.glyph_code = $urandom;
    q.face_id = 16'($urandom);
    q.size_pixels = 16'($urandom);
    q.render_style = 8'($urandom);
    q.target_cell = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, CELLS - 1));
    q.fill_ok = ($urandom_range(0, 5) != 0);
    q.fill_width = 16'($urandom);
    q.fill_height = 16'($urandom);
    return q;
  endfunction

  function automatic req_t keyed_get();
    req_t q;
    int   k;
    q = rand_word(MODE_GET);
    k = $urandom_range(0, 7);
    q.glyph_code = key_glyph[k];
    {q.face_id, q.size_pixels, q.render_style} = key_attrs[k];
    return q;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        cache_rsp_q.push_back(cache_apply(req_if.data));
        void'(req_q.pop_front());
      end
      if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data <= req_q[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (cache_rsp_q.size() == 0) begin
          report_mismatch("unexpected word", rsp_if.data.status, 0);
        end else begin
          rsp_t w;
          w = cache_rsp_q.pop_front();
          if (rsp_if.data.status !== w.status)
            report_mismatch("status", rsp_if.data.status, w.status);
          if (rsp_if.data.cell_index !== w.cell_index)
            report_mismatch("cell_index", rsp_if.data.cell_index, w.cell_index);
          if (rsp_if.data.glyph_width !== w.glyph_width)
            report_mismatch("glyph_width", rsp_if.data.glyph_width, w.glyph_width);
          if (rsp_if.data.glyph_height !== w.glyph_height)
            report_mismatch("glyph_height", rsp_if.data.glyph_height, w.glyph_height);
          if (rsp_if.data.hit_count !== w.hit_count)
            report_mismatch("hit_count", rsp_if.data.hit_count, w.hit_count);
          if (rsp_if.data.miss_count !== w.miss_count)
            report_mismatch("miss_count", rsp_if.data.miss_count, w.miss_count);
          if (rsp_if.data.eviction_count !== w.eviction_count)
            report_mismatch("eviction_count", rsp_if.data.eviction_count, w.eviction_count);
        end
      end
      rsp_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    req_t q;
    int   r;
    for (int i = 0; i < CELLS; i++) begin
      m_valid[i] = 1'b0;
      m_pins[i] = '0;
      m_age[i] = i;
      m_glyph[i] = '0;
      m_attrs[i] = '0;
      m_dims[i] = '0;
    end
    m_pend = 1'b0;
    m_pend_cell = 0;
    m_pend_glyph = '0;
    m_pend_attrs = '0;
    m_hits = '0;
    m_misses = '0;
    m_evicts = '0;
    for (int k = 0; k < 8; k++) begin
      key_glyph[k] = $urandom;
      key_attrs[k] = 40'({$urandom, $urandom});
    end
    key_glyph[0] = '1;
    key_attrs[0] = '1;
    key_glyph[1] = '0;
    key_attrs[1] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: invalid fill, mode 3, bad release, miss, busy, fills, hit, release
    q = rand_word(MODE_FILL); req_q.push_back(q);
    q = rand_word(2'd3); req_q.push_back(q);
    q = rand_word(MODE_REL); q.target_cell = 16'hFFFF; req_q.push_back(q);
    q = rand_word(MODE_REL); q.target_cell = 16'(CELLS); req_q.push_back(q);
    q = rand_word(MODE_REL); q.target_cell = '0; req_q.push_back(q);
    q = keyed_get(); q.glyph_code = key_glyph[0];
    {q.face_id, q.size_pixels, q.render_style} = key_attrs[0];
    req_q.push_back(q);
    req_q.push_back(q);
    q = rand_word(MODE_FILL); q.fill_ok = 1'b1; q.fill_width = '1; q.fill_height = '1;
    req_q.push_back(q);
    q = keyed_get(); q.glyph_code = key_glyph[0];
    {q.face_id, q.size_pixels, q.render_style} = key_attrs[0];
    req_q.push_back(q);
    q.glyph_code = key_glyph[1]; {q.face_id, q.size_pixels, q.render_style} = key_attrs[1];
    req_q.push_back(q);
    q = rand_word(MODE_FILL); q.fill_ok = 1'b0; req_q.push_back(q);
    q = keyed_get(); q.glyph_code = key_glyph[1];
    {q.face_id, q.size_pixels, q.render_style} = key_attrs[1];
    req_q.push_back(q);
    q = rand_word(MODE_FILL); q.fill_ok = 1'b1; q.fill_width = '0; q.fill_height = '0;
    req_q.push_back(q);
    q = rand_word(MODE_REL); q.target_cell = '0; req_q.push_back(q);
    req_q.push_back(q);
    req_q.push_back(q);

    // random: mostly get/fill pairs with reused keys, some releases and noise
    for (int n = 0; n < 400; n++) begin
      if (n == 140) begin
        wait (req_q.size() == 0);
        send_idle_pct = 49;
        recv_idle_pct = 12;
      end
      if (n == 280) begin
        wait (req_q.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while requests keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      r = $urandom_range(0, 99);
      if (n >= 160 && n < 240) begin
        // fill the whole cache with pinned cells to reach all-pinned
        q = rand_word(MODE_GET); req_q.push_back(q);
        q = rand_word(MODE_FILL); q.fill_ok = 1'b1; req_q.push_back(q);
      end else if (r < 55) begin
        q = (r < 35) ? keyed_get() : rand_word(MODE_GET);
        req_q.push_back(q);
        q = rand_word(MODE_FILL); req_q.push_back(q);
      end else if (r < 85) begin
        req_q.push_back(rand_word(MODE_REL));
      end else begin
        req_q.push_back(rand_word(2'($urandom_range(0, 3))));
      end
    end

    wait (req_q.size() == 0 && !req_if.valid);
    while (cache_rsp_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && cache_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
